[rtl/assert_macros.svh]
// Assertion macros shared by the packed list parser RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PLEP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true out of reset
`define PLEP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/plep_pkg.sv]
// Shared types and constants for the packed list entry header parser.
// No dependencies.
package plep_pkg;

	localparam int HEADER_BYTES = 10;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PREV  = 1'd1;

	// encoding byte codes
	localparam logic [7:0] ENC_STR6   = 8'h00;
	localparam logic [7:0] ENC_STR14  = 8'h40;
	localparam logic [7:0] ENC_STR32  = 8'h80;
	localparam logic [7:0] ENC_INT16  = 8'hc0;
	localparam logic [7:0] ENC_INT32  = 8'hd0;
	localparam logic [7:0] ENC_INT64  = 8'he0;
	localparam logic [7:0] ENC_INT24  = 8'hf0;
	localparam logic [7:0] ENC_IMM_LO = 8'hf1;
	localparam logic [7:0] ENC_IMM_HI = 8'hfd;
	localparam logic [7:0] ENC_INT8   = 8'hfe;
	localparam logic [7:0] STR_MASK   = 8'hc0;
	localparam logic [7:0] PREV_WIDE  = 8'hfe;
	localparam logic [7:0] END_MARK   = 8'hff;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_BADENC = 3'd1,
		ST_BEYOND = 3'd2,
		ST_PREV   = 3'd3,
		ST_END    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_PREV,
		PH_ENC,
		PH_LEN,
		PH_SKIP
	} phase_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        start;
		logic [31:0] offset;
		logic [7:0]  enc;    // encoding with string length bits cleared
		logic [2:0]  ls;     // header size of this encoding, 0 = bad
		logic [3:0]  int_w;  // integer payload width
	} tok_t;

endpackage

[rtl/plep_byte_if.sv]
// Byte stream channel into the parser.
// Depends on nothing.
interface plep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       list_start;

	modport source (output valid, output data_byte, output list_start, input ready);
	modport sink (input valid, input data_byte, input list_start, output ready);
endinterface

[rtl/plep_desc_if.sv]
// Entry descriptor channel out of the parser.
// Depends on nothing.
interface plep_desc_if;
	logic        valid;
	logic        ready;
	logic [31:0] entry_offset;
	logic [31:0] prev_length;
	logic [2:0]  prev_length_size;
	logic [7:0]  encoding_byte;
	logic [2:0]  length_size;
	logic [31:0] data_length;
	logic [2:0]  status;

	modport source (output valid, output entry_offset, output prev_length,
		output prev_length_size, output encoding_byte, output length_size,
		output data_length, output status, input ready);
	modport sink (input valid, input entry_offset, input prev_length,
		input prev_length_size, input encoding_byte, input length_size,
		input data_length, input status, output ready);
endinterface

[rtl/plep_front.sv]
// Front end: accepts bytes, tracks the byte offset and classifies encodings.
// Depends on plep_pkg and plep_byte_if.
module plep_front import plep_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	plep_byte_if.sink stream,
	input  logic      q_full,
	output logic      push,
	output tok_t      tok
);

	logic [31:0] cur_off_q;
	logic [31:0] off;
	logic [7:0]  b;
	logic [7:0]  enc;

	assign stream.ready = !q_full;
	assign push = stream.valid && stream.ready;
	assign b = stream.data_byte;
	assign off = stream.list_start ? 32'(HEADER_BYTES) : cur_off_q;
	assign enc = (b < STR_MASK) ? (b & STR_MASK) : b;

	always_comb begin
		tok.data   = b;
		tok.start  = stream.list_start;
		tok.offset = off;
		tok.enc    = enc;
		unique case (enc) inside
			ENC_INT16, ENC_INT32, ENC_INT64, ENC_INT24, ENC_INT8,
			[ENC_IMM_LO:ENC_IMM_HI], ENC_STR6: tok.ls = 3'd1;
			ENC_STR14: tok.ls = 3'd2;
			ENC_STR32: tok.ls = 3'd5;
			default:   tok.ls = 3'd0;
		endcase
		unique case (enc)
			ENC_INT8:  tok.int_w = 4'd1;
			ENC_INT16: tok.int_w = 4'd2;
			ENC_INT24: tok.int_w = 4'd3;
			ENC_INT32: tok.int_w = 4'd4;
			ENC_INT64: tok.int_w = 4'd8;
			default:   tok.int_w = 4'd0;
		endcase
	end

	// offset wraps modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_off_q <= '0;
		end else if (push) begin
			cur_off_q <= off + 32'd1;
		end
	end

endmodule

[rtl/plep_queue.sv]
// Short queue of classified bytes between front and back.
// Depends on plep_pkg.
`include "assert_macros.svh"
module plep_queue import plep_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t wr,
	output logic full,
	input  logic pop,
	output tok_t rd,
	output logic not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`PLEP_ASSERT_NEVER(a_no_overflow, push && full && !pop, "queue push while full")
	`PLEP_ASSERT_NEVER(a_no_underflow, pop && !not_empty, "queue pop while empty")

endmodule

[rtl/plep_back.sv]
// Back end: entry header state machine and descriptor output register.
// Depends on plep_pkg and plep_desc_if.
`include "assert_macros.svh"
module plep_back import plep_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tok_t         tok,
	input  logic         tok_valid,
	output logic         tok_pop,
	input  logic [31:0]  total_bytes,
	input  logic         check_prev,
	plep_desc_if.source  desc
);

	phase_t      phase_q, phase_n, ph;
	logic [31:0] entry_start_q, entry_start_n;
	logic [32:0] base_q, base_n;   // entry start plus previous-length field size
	logic [31:0] prev_len_q, prev_len_n;
	logic [2:0]  prev_size_q, prev_size_n;
	logic [7:0]  enc_q, enc_n;
	logic [31:0] len_acc_q, len_acc_n;
	logic [2:0]  idx_q, idx_n;
	logic [31:0] remain_q, remain_n;

	logic        out_valid_q;
	logic [31:0] o_entry_q, o_prev_len_q, o_len_q;
	logic [2:0]  o_prev_size_q, o_ls_q;
	logic [7:0]  o_enc_q;
	status_t     o_st_q;

	logic        fire;
	logic        emit;
	status_t     st;
	logic [2:0]  r_ls;
	logic [31:0] r_len;

	logic [7:0]  b;
	logic [31:0] off;
	logic [32:0] start_base;
	logic        hdr_beyond;
	logic [31:0] len_shift;
	logic [2:0]  lsl;
	logic [2:0]  idx_inc;
	logic [2:0]  fin_ls;
	logic [31:0] fin_len;
	logic [33:0] fin_end;
	status_t     fin_st;

	assign fire = tok_valid && (!out_valid_q || desc.ready);
	assign tok_pop = fire;

	assign b = tok.data;
	assign off = tok.offset;
	assign ph = tok.start ? PH_START : phase_q;
	assign start_base = {1'b0, off} + ((b == PREV_WIDE) ? 33'd5 : 33'd1);
	assign hdr_beyond = ({1'b0, off} + 33'(tok.ls)) >= {1'b0, total_bytes};
	assign len_shift = {len_acc_q[23:0], b};
	assign lsl = (enc_q == ENC_STR14) ? 3'd2 : 3'd5;
	assign idx_inc = idx_q + 3'd1;
	assign fin_ls = (ph == PH_LEN) ? lsl : 3'd1;
	assign fin_len = (ph == PH_LEN) ? len_shift :
		(tok.enc == ENC_STR6) ? {26'd0, b[5:0]} : {28'd0, tok.int_w};
	assign fin_end = {1'b0, base_q} + 34'(fin_ls) + 34'(fin_len);

	always_comb begin
		if (fin_end >= {2'b0, total_bytes}) begin
			fin_st = ST_BEYOND;
		end else if (check_prev &&
			({1'b0, entry_start_q} < {1'b0, prev_len_q} + 33'(HEADER_BYTES))) begin
			fin_st = ST_PREV;
		end else begin
			fin_st = ST_OK;
		end
	end

	always_comb begin
		phase_n       = phase_q;
		entry_start_n = entry_start_q;
		base_n        = base_q;
		prev_len_n    = prev_len_q;
		prev_size_n   = prev_size_q;
		enc_n         = enc_q;
		len_acc_n     = len_acc_q;
		idx_n         = idx_q;
		remain_n      = remain_q;
		emit          = 1'b0;
		st            = ST_OK;
		r_ls          = 3'd0;
		r_len         = '0;
		unique case (ph)
			PH_START: begin
				entry_start_n = off;
				base_n        = start_base;
				prev_len_n    = '0;
				prev_size_n   = 3'd0;
				enc_n         = '0;
				len_acc_n     = '0;
				idx_n         = '0;
				if ({1'b0, off} >= {1'b0, total_bytes}) begin
					emit = 1'b1;
					st   = ST_BEYOND;
				end else if (b == END_MARK) begin
					emit = 1'b1;
					st   = ST_END;
				end else begin
					if (b == PREV_WIDE) begin
						prev_size_n = 3'd5;
						phase_n     = PH_PREV;
					end else begin
						prev_size_n = 3'd1;
						prev_len_n  = {24'd0, b};
						phase_n     = PH_ENC;
					end
					// field must end inside the list
					if (start_base >= {1'b0, total_bytes}) begin
						emit = 1'b1;
						st   = ST_BEYOND;
					end
				end
			end
			PH_PREV: begin
				prev_len_n = prev_len_q | ({24'd0, b} << {idx_q[1:0], 3'b000});
				idx_n = idx_inc;
				if (idx_inc[2]) begin
					phase_n = PH_ENC;
				end
			end
			PH_ENC: begin
				enc_n = tok.enc;
				if (tok.ls == 3'd0) begin
					emit = 1'b1;
					st   = ST_BADENC;
				end else if (hdr_beyond) begin
					emit = 1'b1;
					st   = ST_BEYOND;
					r_ls = tok.ls;
				end else if (tok.enc == ENC_STR14) begin
					len_acc_n = {26'd0, b[5:0]};
					idx_n     = '0;
					phase_n   = PH_LEN;
				end else if (tok.enc == ENC_STR32) begin
					len_acc_n = '0;
					idx_n     = '0;
					phase_n   = PH_LEN;
				end else begin
					emit  = 1'b1;
					st    = fin_st;
					r_ls  = fin_ls;
					r_len = fin_len;
					if (fin_st == ST_OK) begin
						phase_n  = (fin_len == '0) ? PH_START : PH_SKIP;
						remain_n = fin_len;
					end
				end
			end
			PH_LEN: begin
				len_acc_n = len_shift;
				idx_n     = idx_inc;
				if (idx_inc >= lsl - 3'd1) begin
					emit  = 1'b1;
					st    = fin_st;
					r_ls  = fin_ls;
					r_len = fin_len;
					if (fin_st == ST_OK) begin
						phase_n  = (fin_len == '0) ? PH_START : PH_SKIP;
						remain_n = fin_len;
					end
				end
			end
			PH_SKIP: begin
				remain_n = remain_q - 32'd1;
				if (remain_q == 32'd1) begin
					phase_n = PH_START;
				end
			end
			PH_IDLE: begin
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
		if (emit && st != ST_OK) begin
			phase_n = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			entry_start_q <= '0;
			base_q        <= '0;
			prev_len_q    <= '0;
			prev_size_q   <= '0;
			enc_q         <= '0;
			len_acc_q     <= '0;
			idx_q         <= '0;
			remain_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				phase_q       <= phase_n;
				entry_start_q <= entry_start_n;
				base_q        <= base_n;
				prev_len_q    <= prev_len_n;
				prev_size_q   <= prev_size_n;
				enc_q         <= enc_n;
				len_acc_q     <= len_acc_n;
				idx_q         <= idx_n;
				remain_q      <= remain_n;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (desc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			o_entry_q     <= entry_start_n;
			o_prev_len_q  <= prev_len_n;
			o_prev_size_q <= prev_size_n;
			o_enc_q       <= enc_n;
			o_ls_q        <= r_ls;
			o_len_q       <= r_len;
			o_st_q        <= st;
		end
	end

	assign desc.valid            = out_valid_q;
	assign desc.entry_offset     = o_entry_q;
	assign desc.prev_length      = o_prev_len_q;
	assign desc.prev_length_size = o_prev_size_q;
	assign desc.encoding_byte    = o_enc_q;
	assign desc.length_size      = o_ls_q;
	assign desc.data_length      = o_len_q;
	assign desc.status           = o_st_q;

	`PLEP_ASSERT(a_err_halts, (fire && emit && st != ST_OK) |=> phase_q == PH_IDLE, "error did not halt parse")
	`PLEP_ASSERT(a_skip_nonzero, phase_q == PH_SKIP |-> remain_q != 32'd0, "skip with nothing left")
	`PLEP_ASSERT(a_no_drop, (out_valid_q && !desc.ready) |-> !fire, "byte consumed while result stalled")

endmodule

[rtl/packed_list_entry_header_parser.sv]
// Packed list entry header parser. Takes one list byte per cycle on the stream channel
// and gives one descriptor per entry header (or per error / end marker) on desc. A front
// stage classifies each byte and tags it with its offset, a small queue decouples it from
// the back-end header state machine, and a descriptor register feeds the output. Sustained
// rate is one byte per cycle, set by the back end retiring one queued byte each cycle while
// no held output stalls it; a descriptor is registered when its last header byte is taken.
// The user must write configuration only while the block is idle, which is not enforced.
module packed_list_entry_header_parser import plep_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	plep_byte_if.sink            stream,
	plep_desc_if.source          desc,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata
);

	logic [31:0] total_bytes_q;
	logic        check_prev_q;

	logic push;
	logic pop;
	logic q_full;
	logic q_valid;
	tok_t wr_tok;
	tok_t rd_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bytes_q <= 32'd11;
			check_prev_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_TOTAL_BYTES) begin
				total_bytes_q <= cfg_wdata;
			end
			if (cfg_index == REG_CHECK_PREV) begin
				check_prev_q <= cfg_wdata[0];
			end
		end
	end

	plep_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.q_full (q_full),
		.push   (push),
		.tok    (wr_tok)
	);

	plep_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr        (wr_tok),
		.full      (q_full),
		.pop       (pop),
		.rd        (rd_tok),
		.not_empty (q_valid)
	);

	plep_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok         (rd_tok),
		.tok_valid   (q_valid),
		.tok_pop     (pop),
		.total_bytes (total_bytes_q),
		.check_prev  (check_prev_q),
		.desc        (desc)
	);

endmodule

[dv/plep_desc_checker.sv]
`timescale 1ns / 100ps
// Descriptor checker for the packed list entry header parser: tracks the parse of every
// accepted byte, queues the descriptors it should produce and compares them in order.
// Depends on plep_pkg, plep_byte_if and plep_desc_if.
module plep_desc_checker import plep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	plep_byte_if                 stream,
	plep_desc_if                 desc,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	output int                   mismatches,
	output int                   waiting,
	output int                   checked,
	output int                   ok_seen
);

	localparam logic [7:0] LEN6_MASK  = 8'h3f;
	localparam int         MAX_PRINTS = 40;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] prev_len;
		logic [2:0]  prev_size;
		logic [7:0]  enc;
		logic [2:0]  hdr_size;
		logic [31:0] data_len;
		logic [2:0]  st;
	} entry_desc_t;

	entry_desc_t expected_descs[$];

	// register copies
	logic [31:0] total_bytes_r;
	logic        check_prev_r;

	// parse state
	phase_t      parse_st;
	logic [2:0]  field_idx;
	logic [31:0] cur_off;
	logic [31:0] entry_start;
	logic [31:0] prev_len;
	logic [2:0]  prev_size;
	logic [7:0]  enc_r;
	logic [31:0] len_acc;
	logic [31:0] skip_left;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic int header_size(input logic [7:0] e);
		if (e == ENC_STR6 || e == ENC_INT16 || e == ENC_INT32 || e == ENC_INT64 ||
				e == ENC_INT24 || e == ENC_INT8 || (e >= ENC_IMM_LO && e <= ENC_IMM_HI))
			return 1;
		if (e == ENC_STR14)
			return 2;
		if (e == ENC_STR32)
			return 5;
		return 0;
	endfunction

	function automatic logic [31:0] int_bytes(input logic [7:0] e);
		case (e)
			ENC_INT8:  return 32'd1;
			ENC_INT16: return 32'd2;
			ENC_INT24: return 32'd3;
			ENC_INT32: return 32'd4;
			ENC_INT64: return 32'd8;
			default:   return 32'd0;
		endcase
	endfunction

	function automatic void post_desc(input logic [2:0] ls, input logic [31:0] len,
			input status_t st);
		expected_descs.push_back('{entry_start, prev_len, prev_size, enc_r, ls, len, st});
		if (st != ST_OK)
			parse_st = PH_IDLE;
	endfunction

	// header complete: range and back link checks, then skip the payload
	function automatic void close_header(input int ls, input logic [31:0] len);
		longint pos, fin, back, lastv;
		status_t st;
		pos = entry_start;
		back = prev_len;
		lastv = total_bytes_r;
		lastv = lastv - 1;
		fin = len;
		fin = fin + pos + prev_size + ls;
		st = ST_OK;
		if (fin > lastv)
			st = ST_BEYOND;
		else if (check_prev_r && pos - back < HEADER_BYTES)
			st = ST_PREV;
		if (st == ST_OK) begin
			if (len == 0) begin
				parse_st = PH_START;
			end else begin
				parse_st = PH_SKIP;
				skip_left = len;
			end
		end
		post_desc(ls[2:0], len, st);
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic first);
		longint off, lastv;
		int hs;
		if (first) begin
			parse_st = PH_START;
			cur_off = 32'(HEADER_BYTES);
		end
		off = cur_off;
		lastv = total_bytes_r;
		lastv = lastv - 1;
		case (parse_st)
			PH_START: begin
				entry_start = cur_off;
				prev_len = '0;
				prev_size = '0;
				enc_r = '0;
				len_acc = '0;
				field_idx = '0;
				if (off > lastv) begin
					post_desc(3'd0, 32'd0, ST_BEYOND);
				end else if (b == END_MARK) begin
					post_desc(3'd0, 32'd0, ST_END);
				end else if (b == PREV_WIDE) begin
					prev_size = 3'd5;
					if (off + 5 > lastv)
						post_desc(3'd0, 32'd0, ST_BEYOND);
					else
						parse_st = PH_PREV;
				end else begin
					prev_size = 3'd1;
					prev_len = {24'd0, b};
					if (off + 1 > lastv)
						post_desc(3'd0, 32'd0, ST_BEYOND);
					else
						parse_st = PH_ENC;
				end
			end
			PH_PREV: begin
				// little-endian 32-bit back link
				prev_len = prev_len | ({24'd0, b} << (8 * field_idx[1:0]));
				field_idx = field_idx + 3'd1;
				if (field_idx >= 3'd4)
					parse_st = PH_ENC;
			end
			PH_ENC: begin
				enc_r = (b < STR_MASK) ? (b & STR_MASK) : b;
				hs = header_size(enc_r);
				if (hs == 0) begin
					post_desc(3'd0, 32'd0, ST_BADENC);
				end else if (off + hs > lastv) begin
					post_desc(hs[2:0], 32'd0, ST_BEYOND);
				end else if (enc_r == ENC_STR6) begin
					close_header(1, {24'd0, b & LEN6_MASK});
				end else if (enc_r == ENC_STR14) begin
					len_acc = {24'd0, b & LEN6_MASK};
					field_idx = '0;
					parse_st = PH_LEN;
				end else if (enc_r == ENC_STR32) begin
					len_acc = '0;
					field_idx = '0;
					parse_st = PH_LEN;
				end else begin
					close_header(1, int_bytes(enc_r));
				end
			end
			PH_LEN: begin
				// big-endian string length
				hs = (enc_r == ENC_STR14) ? 2 : 5;
				len_acc = {len_acc[23:0], b};
				field_idx = field_idx + 3'd1;
				if (field_idx >= hs - 1)
					close_header(hs, len_acc);
			end
			PH_SKIP: begin
				if (skip_left > 0)
					skip_left = skip_left - 32'd1;
				if (skip_left == 0)
					parse_st = PH_START;
			end
			default: parse_st = PH_IDLE;
		endcase
		cur_off = cur_off + 32'd1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		entry_desc_t want, got;
		if (!arst_n) begin
			total_bytes_r = 32'd11;
			check_prev_r = 1'b0;
			parse_st = PH_IDLE;
			field_idx = '0;
			cur_off = '0;
			entry_start = '0;
			prev_len = '0;
			prev_size = '0;
			enc_r = '0;
			len_acc = '0;
			skip_left = '0;
			expected_descs.delete();
			waiting = 0;
		end else begin
			if (desc.valid && desc.ready) begin
				got = '{desc.entry_offset, desc.prev_length, desc.prev_length_size,
					desc.encoding_byte, desc.length_size, desc.data_length, desc.status};
				checked++;
				if (desc.status == ST_OK)
					ok_seen++;
				if (expected_descs.size() == 0) begin
					report_mismatch($sformatf("descriptor at offset %h with nothing expected",
						desc.entry_offset));
				end else begin
					want = expected_descs.pop_front();
					if (got.offset !== want.offset || got.prev_len !== want.prev_len ||
							got.prev_size !== want.prev_size || got.enc !== want.enc ||
							got.hdr_size !== want.hdr_size || got.data_len !== want.data_len ||
							got.st !== want.st)
						report_mismatch($sformatf(
							"exp off=%h prev=%h/%0d enc=%h ls=%0d len=%h st=%0d, got off=%h prev=%h/%0d enc=%h ls=%0d len=%h st=%0d",
							want.offset, want.prev_len, want.prev_size, want.enc, want.hdr_size,
							want.data_len, want.st, got.offset, got.prev_len, got.prev_size,
							got.enc, got.hdr_size, got.data_len, got.st));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL_BYTES: total_bytes_r = cfg_wdata;
					REG_CHECK_PREV:  check_prev_r = cfg_wdata[0];
					default: ;
				endcase
			end
			if (stream.valid && stream.ready)
				predict_byte(stream.data_byte, stream.list_start);
			waiting = expected_descs.size();
		end
	end

endmodule

[dv/packed_list_entry_header_parser_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the packed list entry header parser: directed and random list
// streams under several register settings and flow-control patterns.
// Depends on plep_pkg, the channel interfaces and plep_desc_checker.
module packed_list_entry_header_parser_tb import plep_pkg::*; ();

	localparam int CLK_PERIOD      = 4;
	localparam int DRAIN_CYCLES    = 4 * QUEUE_DEPTH + 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_BYTES    = 900;
	localparam int PHASES          = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_LIST_SPAN   = 310;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_wdata;

	plep_byte_if byte_ch ();
	plep_desc_if desc_ch ();

	int mismatches, waiting, checked, ok_seen;
	int src_idle_pct, snk_stall_pct;
	bit hold_off;
	int cycles;
	int bytes_sent, lists_sent, settings;

	logic [7:0] list_bytes[$];

	packed_list_entry_header_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (byte_ch),
		.desc      (desc_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	plep_desc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (byte_ch),
		.desc       (desc_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.waiting    (waiting),
		.checked    (checked),
		.ok_seen    (ok_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d descriptors outstanding", cycles, waiting);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// descriptor receiver
	always @(negedge clk) begin
		if (hold_off)
			desc_ch.ready <= 1'b0;
		else
			desc_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic push_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.list_start <= first;
		do @(posedge clk); while (!byte_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering, wait for every descriptor, then let payload bytes drain
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_list();
		lists_sent++;
		foreach (list_bytes[i])
			push_byte(list_bytes[i], i == 0);
		bytes_sent += list_bytes.size();
		// trailing garbage without a list start
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)), 1'b0);
	endtask

	// mostly well-formed list, fitted to total_bytes, with occasional damage
	function automatic void build_list(input logic [31:0] tot);
		logic [7:0]  ent[$];
		logic [31:0] prev_len, plen, dlen;
		longint      lim_off, used;
		int          n, keep;
		bit          stop;
		list_bytes.delete();
		lim_off = tot;
		lim_off = lim_off - 1;
		if (lim_off > MAX_LIST_SPAN)
			lim_off = MAX_LIST_SPAN;
		prev_len = 0;
		stop = 1'b0;
		n = $urandom_range(8, 1);
		for (int i = 0; i < n && !stop; i++) begin
			ent.delete();
			plen = ($urandom_range(11) == 0) ? $urandom_range(300) : prev_len;
			if (plen >= 254 || $urandom_range(7) == 0) begin
				ent.push_back(PREV_WIDE);
				for (int k = 0; k < 4; k++)
					ent.push_back(plen[8*k +: 8]);
			end else begin
				ent.push_back(plen[7:0]);
			end
			case ($urandom_range(7))
				0, 1: begin
					dlen = ($urandom_range(7) == 0) ? 63 : $urandom_range(12);
					ent.push_back(ENC_STR6 | {2'b00, dlen[5:0]});
				end
				2: begin
					dlen = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(40);
					ent.push_back(ENC_STR14 | {2'b00, dlen[13:8]});
					ent.push_back(dlen[7:0]);
				end
				3: begin
					dlen = ($urandom_range(7) == 0) ? $urandom : $urandom_range(30);
					ent.push_back(ENC_STR32);
					for (int k = 3; k >= 0; k--)
						ent.push_back(dlen[8*k +: 8]);
				end
				4, 5: begin
					case ($urandom_range(4))
						0: begin ent.push_back(ENC_INT8);  dlen = 1; end
						1: begin ent.push_back(ENC_INT16); dlen = 2; end
						2: begin ent.push_back(ENC_INT24); dlen = 3; end
						3: begin ent.push_back(ENC_INT32); dlen = 4; end
						default: begin ent.push_back(ENC_INT64); dlen = 8; end
					endcase
				end
				6: begin
					ent.push_back(8'($urandom_range(ENC_IMM_HI, ENC_IMM_LO)));
					dlen = 0;
				end
				default: begin
					// upper encoding space, bad codes among them
					ent.push_back(8'($urandom_range(255, 192)));
					dlen = $urandom_range(4);
				end
			endcase
			used = dlen;
			used = used + HEADER_BYTES + list_bytes.size() + ent.size();
			if (used > lim_off) begin
				// entry would overrun: sometimes leave its header in to hit the range check
				if ($urandom_range(1) == 1)
					foreach (ent[k]) list_bytes.push_back(ent[k]);
				stop = 1'b1;
			end else begin
				foreach (ent[k]) list_bytes.push_back(ent[k]);
				repeat (dlen) list_bytes.push_back(8'($urandom_range(255)));
				prev_len = ent.size() + dlen;
			end
		end
		if (!stop && $urandom_range(9) != 0)
			list_bytes.push_back(END_MARK);
		if (list_bytes.size() == 0)
			list_bytes.push_back(8'($urandom_range(255)));
		if ($urandom_range(7) == 0)
			list_bytes[$urandom_range(list_bytes.size() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(11) == 0 && list_bytes.size() > 1) begin
			keep = $urandom_range(list_bytes.size() - 1, 1);
			while (list_bytes.size() > keep)
				void'(list_bytes.pop_back());
		end
	endfunction

	initial begin
		logic [31:0] tot;
		int phase_bytes;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TOTAL_BYTES;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.list_start = 1'b0;
		desc_ch.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_off = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// smallest list: end marker, then headers that cannot fit
		write_reg(REG_TOTAL_BYTES, 32'd11);
		write_reg(REG_CHECK_PREV, 32'd0);
		settings++;
		list_bytes = '{END_MARK};
		send_list();
		list_bytes = '{8'h00};
		send_list();
		list_bytes = '{PREV_WIDE};
		send_list();
		push_byte(8'h5a, 1'b0);
		settle();

		// largest size with back link check: immediate, integer and long string encodings, bad code,
		// back link below the first entry
		write_reg(REG_TOTAL_BYTES, 32'hffff_ffff);
		write_reg(REG_CHECK_PREV, 32'd1);
		settings++;
		list_bytes = '{8'h00, ENC_IMM_LO, 8'h02, ENC_INT8, 8'h80,
			8'h03, ENC_STR14, 8'h02, 8'haa, 8'hbb,
			8'h05, ENC_STR32, 8'h00, 8'h00, 8'h00, 8'h01, 8'hcc,
			8'h7f, 8'hc7};  // last one is a bad encoding
		send_list();
		list_bytes = '{8'h01, ENC_IMM_HI};
		send_list();
		settle();

		// short blob: entry past the end, wide back link, header past the end
		// after a restart in the middle of an entry
		write_reg(REG_TOTAL_BYTES, 32'd16);
		write_reg(REG_CHECK_PREV, 32'd0);
		settings++;
		list_bytes = '{8'h00, ENC_INT64};
		send_list();
		list_bytes = '{PREV_WIDE, 8'h01};
		send_list();
		list_bytes = '{8'h00, ENC_STR32};
		send_list();
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: tot = 32'hffff_ffff;
				1: tot = 32'd11;
				default: tot = ($urandom_range(3) == 0) ? $urandom_range(32'hffff_fffe, 1000)
					: $urandom_range(320, 24);
			endcase
			write_reg(REG_TOTAL_BYTES, tot);
			write_reg(REG_CHECK_PREV, 32'(p % 2));
			settings++;
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
				default: begin src_idle_pct = 30; snk_stall_pct = 30; end
			endcase
			// long receiver stall while bytes keep coming
			if (p == 4)
				fork
					begin
						@(posedge clk);
						hold_off = 1'b1;
						repeat (HOLD_OFF_CYCLES) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			phase_bytes = 0;
			while (phase_bytes < RANDOM_BYTES / PHASES) begin
				build_list(tot);
				send_list();
				phase_bytes += list_bytes.size();
			end
			settle();
		end

		$display("Sent %0d list bytes in %0d lists under %0d register settings",
			bytes_sent, lists_sent, settings);
		$display("Checked %0d descriptors, %0d of them clean entries", checked, ok_seen);
		if (mismatches == 0 && waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
